// ----- sv/tklt_pkg.sv -----
// Package for the top-k largest tracker: field widths, mode codes and the
// entry and cell control types shared by the cell chain and the top level.
// No dependencies.
package tklt_pkg;

  localparam int SIZE_W          = 63;
  localparam int TAG_W           = 32;
  localparam int TOPC_W          = 6;
  localparam int MAX_ENTRIES_DEF = 32;

  localparam logic [TOPC_W-1:0] TOPC_RESET = 6'd20;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins_en;  // insert the offered entry at its sorted place
    logic rot_en;  // rotate the held list one place toward cell zero
  } cell_ctrl_t;

endpackage

// ----- sv/tklt_cell.sv -----
// One cell of the sorted chain: holds one entry, compares it against the
// offered entry and takes its neighbor's entry on insert or rotate.
// Depends on tklt_pkg.
module tklt_cell
  import tklt_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     new_entry,
  input  logic       occ,        // this cell holds a live entry
  input  logic       take_prev,  // the cell above also moves this cycle
  input  entry_t     prev_entry,
  input  entry_t     next_entry,
  input  entry_t     wrap_entry,
  input  logic       wrap,       // this cell is the last live one
  output entry_t     entry,
  output logic       lt,
  output logic       take
);

  entry_t entry_r;
  entry_t entry_nxt;

  // Strictly smaller keeps older equal entries ahead of the offered one.
  assign lt    = occ && (entry_r.size < new_entry.size);
  assign take  = !occ || lt;
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins_en && take) begin
      entry_nxt = take_prev ? prev_entry : new_entry;
    end else if (ctrl.rot_en) begin
      entry_nxt = wrap ? wrap_entry : next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- sv/top_k_largest_tracker_unit.sv -----
// Top level of the top-k largest tracker: control, count, output register
// and the chain of tklt_cell instances. Depends on tklt_pkg and tklt_cell.
//
//   channel | direction | ports                                   | handshake
//   --------+-----------+-----------------------------------------+-----------------
//   in      | input     | in_mode, in_entry_size, in_entry_tag    | in_valid/in_ready
//   out     | output    | out_size, out_tag, out_valid, out_last  | out_item_valid/out_item_ready
//   cfg     | input     | cfg_wr_data (top_count)                 | cfg_wr_en, no wait
//
// Insert and clear items can follow back to back. A read item is accepted and
// then gives one output item per held entry (a single item for an empty list),
// in the order set by the rotation of the cell chain through cell zero; a stalled
// output holds the rotation. No item is accepted during a read.
// Reset (rst_n low, synchronous) empties the list and sets top_count to 20.
module top_k_largest_tracker_unit
  import tklt_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [SIZE_W-1:0] in_entry_size,
  input  logic [TAG_W-1:0]  in_entry_tag,
  output logic              out_item_valid,
  input  logic              out_item_ready,
  output logic [SIZE_W-1:0] out_size,
  output logic [TAG_W-1:0]  out_tag,
  output logic              out_valid,
  output logic              out_last,
  input  logic              cfg_wr_en,
  input  logic [TOPC_W-1:0] cfg_wr_data
);

  // Count width holds MAX_ENTRIES itself; the limit compare runs wide
  // enough for both the count and the six-bit register.
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = (CW > TOPC_W) ? CW : TOPC_W;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_ENTRIES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic              state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     rd_left_r, rd_left_nxt;
  logic [TOPC_W-1:0] top_count_r, top_count_nxt;

  logic              ovld_r, ovld_nxt;
  logic [SIZE_W-1:0] osize_r, osize_nxt;
  logic [TAG_W-1:0]  otag_r, otag_nxt;
  logic              ofv_r, ofv_nxt;
  logic              olast_r, olast_nxt;

  entry_t     new_entry;
  entry_t     cell_q [MAX_ENTRIES];
  logic       cell_lt   [MAX_ENTRIES];
  logic       cell_take [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] lt_vec;
  cell_ctrl_t ctrl;

  logic          in_acc;
  logic [LW-1:0] limit;
  logic [LW-1:0] cnt_l;
  logic          not_full;
  logic          any_lt;
  logic          emit;
  logic          ins_go;

  assign new_entry.size = in_entry_size;
  assign new_entry.tag  = in_entry_tag;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // A top_count above the chain length saturates to the chain length.
  assign limit    = (LW'(top_count_r) > MAX_L) ? MAX_L : LW'(top_count_r);
  assign cnt_l    = LW'(cnt_r);
  assign not_full = cnt_l < limit;

  // The list is sorted, so any live cell smaller than the offered entry
  // means the smallest one is too: the full-list replacement condition.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      lt_vec[i] = cell_lt[i];
    end
  end
  assign any_lt = |lt_vec;

  assign ins_go = in_acc && (in_mode == MODE_INSERT) && (limit != '0) &&
                  (not_full || any_lt);

  // During a read of a non-empty list the chain rotates once for every item handed
  // to the output register, so cell zero always shows the next entry to send.
  assign emit = (state_r == ST_READ) && (!ovld_r || out_item_ready);

  assign ctrl.ins_en = ins_go;
  assign ctrl.rot_en = emit && (cnt_r != '0);

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   take_p;
    if (i == 0) begin : g_head
      assign prev_e = new_entry;
      assign take_p = 1'b0;
    end else begin : g_body
      assign prev_e = cell_q[i-1];
      assign take_p = cell_take[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign next_e = cell_q[0];
    end else begin : g_mid
      assign next_e = cell_q[i+1];
    end

    tklt_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_entry  (new_entry),
      .occ        (CW'(i) < cnt_r),
      .take_prev  (take_p),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .wrap_entry (cell_q[0]),
      .wrap       (CW'(i) == cnt_r - CW'(1)),
      .entry      (cell_q[i]),
      .lt         (cell_lt[i]),
      .take       (cell_take[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_left_nxt   = rd_left_r;
    top_count_nxt = cfg_wr_en ? cfg_wr_data : top_count_r;
    ovld_nxt      = ovld_r;
    osize_nxt     = osize_r;
    otag_nxt      = otag_r;
    ofv_nxt       = ofv_r;
    olast_nxt     = olast_r;

    if (ovld_r && out_item_ready) begin
      ovld_nxt = 1'b0;
    end

    if (in_acc) begin
      case (in_mode)
        MODE_INSERT: begin
          if (ins_go && not_full) begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        MODE_READ: begin
          state_nxt   = ST_READ;
          rd_left_nxt = cnt_r;
        end
        MODE_CLEAR: begin
          cnt_nxt = '0;
        end
        default: begin
        end
      endcase
    end

    if (emit) begin
      ovld_nxt  = 1'b1;
      ofv_nxt   = (cnt_r != '0);
      olast_nxt = (rd_left_r <= CW'(1));
      osize_nxt = (cnt_r != '0) ? cell_q[0].size : '0;
      otag_nxt  = (cnt_r != '0) ? cell_q[0].tag : '0;
      if (rd_left_r <= CW'(1)) begin
        state_nxt   = ST_IDLE;
        rd_left_nxt = '0;
      end else begin
        rd_left_nxt = rd_left_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rd_left_r   <= '0;
      top_count_r <= TOPC_RESET;
      ovld_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_left_r   <= rd_left_nxt;
      top_count_r <= top_count_nxt;
      ovld_r      <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    osize_r <= osize_nxt;
    otag_r  <= otag_nxt;
    ofv_r   <= ofv_nxt;
    olast_r <= olast_nxt;
  end

  assign out_item_valid = ovld_r;
  assign out_size       = osize_r;
  assign out_tag        = otag_r;
  assign out_valid      = ofv_r;
  assign out_last       = olast_r;

  // The count never runs past the length of the chain.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ENTRIES))
    else $error("entry count exceeds chain length");

  // An item that reports an empty list is always the final item of its read.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_item_valid && !out_valid |-> out_last)
    else $error("empty-list item not marked last");

  // An insert into a list below its limit grows the count by exactly one.
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ins_go && not_full |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("insert below limit did not grow the count");

endmodule
